// File: hw/rtl/fair_reader_writer_lock_arbiter_defines.svh
// assertion helpers for the lock arbiter
// both use clk and sync active-low rst_n of the including module
`ifndef FAIR_READER_WRITER_LOCK_ARBITER_DEFINES_SVH
`define FAIR_READER_WRITER_LOCK_ARBITER_DEFINES_SVH

// same-cycle implication
`define FRWL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lock arbiter check failed");

// next-cycle implication
`define FRWL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lock arbiter check failed");

`endif

// File: hw/rtl/frwl_pkg.sv
// ----------------------------------------------------------------------------
// frwl_pkg
// Types, constants and helpers shared by the reader/writer lock arbiter.
// ----------------------------------------------------------------------------
package frwl_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int MAX_RESULTS = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);
  localparam int READERS_W   = 9;
  localparam int ENTRY_W     = ID_BITS + 1;
  localparam logic [READERS_W-1:0] READERS_MAX = {READERS_W{1'b1}};

  typedef enum logic [1:0] {
    OP_READ_REQ  = 2'd0,
    OP_WRITE_REQ = 2'd1,
    OP_READ_REL  = 2'd2,
    OP_WRITE_REL = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    RK_GRANTED     = 3'd0,
    RK_QUEUED      = 3'd1,
    RK_REJECTED    = 3'd2,
    RK_WAITER_GRANT = 3'd3,
    RK_RELEASED    = 3'd4,
    RK_REL_ERROR   = 3'd5
  } result_kind_t;

  typedef struct packed {
    opcode_t              opcode;
    logic [ID_BITS-1:0]   requester_id;
  } in_item_t;

  typedef struct packed {
    result_kind_t         result_kind;
    logic [ID_BITS-1:0]   agent_id;
    logic                 is_write;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic serve;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic grant_ok;
    logic out_free;
    logic writer_active;
    logic readers_zero;
  } dp_sts_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/frwl_ram.sv
// ----------------------------------------------------------------------------
// frwl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module frwl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/frwl_ctrl.sv
// ----------------------------------------------------------------------------
// frwl_ctrl
// Controller: takes one item, then serves the wait queue head per cycle while the output register is free.
// ----------------------------------------------------------------------------
module frwl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  frwl_pkg::dp_sts_t   sts,
  output frwl_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_CHECK = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // the pending result leaves only once the output register frees up
        if (sts.out_free) begin
          if (sts.grant_ok) begin
            cmd.serve = 1'b1;
          end else begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/frwl_datapath.sv
// ----------------------------------------------------------------------------
// frwl_datapath
// Lock state, wait queue, pending result and output register.
// ----------------------------------------------------------------------------
module frwl_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  frwl_pkg::ctrl_cmd_t  cmd,
  output frwl_pkg::dp_sts_t    sts,
  input  frwl_pkg::in_item_t   in_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output frwl_pkg::out_item_t  out_data
);

  logic [frwl_pkg::PTR_W-1:0]     head_r, head_nxt, tail_r, tail_nxt;
  logic [frwl_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [frwl_pkg::READERS_W-1:0] readers_r, readers_nxt;
  logic                           writer_r, writer_nxt;
  logic [frwl_pkg::RES_W-1:0]     nres_r, nres_nxt;
  frwl_pkg::out_item_t            pend_r, pend_nxt;
  logic                           out_valid_r, out_valid_nxt;
  frwl_pkg::out_item_t            out_data_r, out_data_nxt;

  logic                           enq;
  logic [frwl_pkg::ENTRY_W-1:0]   head_entry;
  logic [frwl_pkg::ENTRY_W-1:0]   wr_entry, ram_rd_data, byp_data_r;
  logic                           byp_r, byp_nxt;
  logic                           head_is_write;
  logic                           full, queue_busy, readers_zero;

  assign wr_entry = {(in_data.opcode == frwl_pkg::OP_WRITE_REQ), in_data.requester_id};

  frwl_ram #(
    .WIDTH (frwl_pkg::ENTRY_W),
    .DEPTH (frwl_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .wr_en   (enq),
    .wr_addr (tail_r),
    .wr_data (wr_entry),
    .rd_addr (head_nxt),
    .rd_data (ram_rd_data)
  );

  // an entry pushed into an empty queue is not yet on the registered read port
  assign byp_nxt       = enq && !queue_busy;
  assign head_entry    = byp_r ? byp_data_r : ram_rd_data;
  assign head_is_write = head_entry[frwl_pkg::ID_BITS];
  assign full          = (count_r == frwl_pkg::CNT_W'(frwl_pkg::QUEUE_DEPTH));
  assign queue_busy    = (count_r != '0);
  assign readers_zero  = (readers_r == '0);

  always_comb begin
    sts.out_free      = !out_valid_r || out_ready;
    sts.writer_active = writer_r;
    sts.readers_zero  = readers_zero;
    sts.grant_ok      = queue_busy && !writer_r &&
                        (nres_r < frwl_pkg::RES_W'(frwl_pkg::MAX_RESULTS)) &&
                        (head_is_write ? readers_zero
                                       : (readers_r != frwl_pkg::READERS_MAX));
  end

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    readers_nxt   = readers_r;
    writer_nxt    = writer_r;
    nres_nxt      = nres_r;
    pend_nxt      = pend_r;
    enq           = 1'b0;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.accept) begin
      nres_nxt          = frwl_pkg::RES_W'(1);
      pend_nxt.agent_id = in_data.requester_id;
      pend_nxt.last     = 1'b0;
      pend_nxt.is_write = (in_data.opcode == frwl_pkg::OP_WRITE_REQ) ||
                          (in_data.opcode == frwl_pkg::OP_WRITE_REL);
      unique case (in_data.opcode)
        frwl_pkg::OP_READ_REQ: begin
          if (full) begin
            pend_nxt.result_kind = frwl_pkg::RK_REJECTED;
          end else if (queue_busy || writer_r ||
                       readers_r == frwl_pkg::READERS_MAX) begin
            enq                  = 1'b1;
            pend_nxt.result_kind = frwl_pkg::RK_QUEUED;
          end else begin
            readers_nxt          = readers_r + frwl_pkg::READERS_W'(1);
            pend_nxt.result_kind = frwl_pkg::RK_GRANTED;
          end
        end
        frwl_pkg::OP_WRITE_REQ: begin
          if (full) begin
            pend_nxt.result_kind = frwl_pkg::RK_REJECTED;
          end else if (queue_busy || writer_r || !readers_zero) begin
            enq                  = 1'b1;
            pend_nxt.result_kind = frwl_pkg::RK_QUEUED;
          end else begin
            writer_nxt           = 1'b1;
            pend_nxt.result_kind = frwl_pkg::RK_GRANTED;
          end
        end
        frwl_pkg::OP_READ_REL: begin
          if (readers_zero) begin
            pend_nxt.result_kind = frwl_pkg::RK_REL_ERROR;
          end else begin
            readers_nxt          = readers_r - frwl_pkg::READERS_W'(1);
            pend_nxt.result_kind = frwl_pkg::RK_RELEASED;
          end
        end
        frwl_pkg::OP_WRITE_REL: begin
          if (!writer_r) begin
            pend_nxt.result_kind = frwl_pkg::RK_REL_ERROR;
          end else begin
            writer_nxt           = 1'b0;
            pend_nxt.result_kind = frwl_pkg::RK_RELEASED;
          end
        end
        default: begin
          pend_nxt.result_kind = frwl_pkg::RK_REL_ERROR;
        end
      endcase
      if (enq) begin
        tail_nxt  = frwl_pkg::ptr_inc(tail_r);
        count_nxt = count_r + frwl_pkg::CNT_W'(1);
      end
    end

    // pending result moves out; last only when nothing else follows
    if (cmd.serve || cmd.finish) begin
      out_valid_nxt     = 1'b1;
      out_data_nxt      = pend_r;
      out_data_nxt.last = cmd.finish;
    end

    if (cmd.serve) begin
      head_nxt  = frwl_pkg::ptr_inc(head_r);
      count_nxt = count_r - frwl_pkg::CNT_W'(1);
      nres_nxt  = nres_r + frwl_pkg::RES_W'(1);
      if (head_is_write) begin
        writer_nxt = 1'b1;
      end else begin
        readers_nxt = readers_r + frwl_pkg::READERS_W'(1);
      end
      pend_nxt.result_kind = frwl_pkg::RK_WAITER_GRANT;
      pend_nxt.agent_id    = head_entry[frwl_pkg::ID_BITS-1:0];
      pend_nxt.is_write    = head_is_write;
      pend_nxt.last        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      readers_r   <= '0;
      writer_r    <= 1'b0;
      nres_r      <= '0;
      out_valid_r <= 1'b0;
      byp_r       <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      readers_r   <= readers_nxt;
      writer_r    <= writer_nxt;
      nres_r      <= nres_nxt;
      out_valid_r <= out_valid_nxt;
      byp_r       <= byp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
    byp_data_r <= wr_entry;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hw/rtl/fair_reader_writer_lock_arbiter.sv
// results: the first is registered in the pending result when an item is taken, then
//   moves to the output register; n results per item (up to 16), one per cycle when
//   the output is not stalled, set by the controller's serve loop on the head
//   entry of the wait queue RAM; no new item is taken until the last is pushed out
// reset: synchronous active-low rst_n empties the queue and frees the lock
// ----------------------------------------------------------------------------
// fair_reader_writer_lock_arbiter
// Reader/writer lock manager with a FIFO of waiters served in order.
// ----------------------------------------------------------------------------
`include "fair_reader_writer_lock_arbiter_defines.svh"

module fair_reader_writer_lock_arbiter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  frwl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output frwl_pkg::out_item_t out_data
);

  frwl_pkg::ctrl_cmd_t cmd;
  frwl_pkg::dp_sts_t   sts;

  frwl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  frwl_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `FRWL_ASSERT_IMPL(a_lock_exclusive, sts.writer_active, sts.readers_zero)
  `FRWL_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `FRWL_ASSERT_NEXT(a_push_on_serve, cmd.serve || cmd.finish, out_valid)
  `FRWL_ASSERT_NEXT(a_last_ends_item, cmd.finish, out_data.last && in_ready)

endmodule

// File: bench/tb_fair_reader_writer_lock_arbiter.sv
// ----------------------------------------------------------------------------
// tb_fair_reader_writer_lock_arbiter
// Self-checking bench for the reader/writer lock arbiter. A behavioral copy
// of the lock state predicts every result of each accepted item. Directed
// tests cover grants, queuing, releases, release errors, a full wait queue
// and the per-item result cap. Random lock traffic then runs under changing
// idle patterns and one long output stall.
// ----------------------------------------------------------------------------
module tb_fair_reader_writer_lock_arbiter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  frwl_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  frwl_pkg::out_item_t out_data;

  // model of the lock
  logic [frwl_pkg::ENTRY_W-1:0] wait_fifo [frwl_pkg::QUEUE_DEPTH];
  int                           fifo_head;
  int                           fifo_tail;
  int                           fifo_count;
  int                           readers_held;
  bit                           writer_held;

  frwl_pkg::out_item_t awaited_results [$];
  int unsigned         fail_count;
  int unsigned         cycle_count;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  hold_request;

  fair_reader_writer_lock_arbiter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fair_reader_writer_lock_arbiter regression: fail");
      $finish;
    end
  end

  // works out all results of one lock operation and updates the lock state
  task automatic arbitrate_lock_op(input frwl_pkg::in_item_t op);
    frwl_pkg::out_item_t          res [$];
    frwl_pkg::out_item_t          r;
    logic [frwl_pkg::ENTRY_W-1:0] head_entry;
    bit                           wr;
    wr = (op.opcode == frwl_pkg::OP_WRITE_REQ) || (op.opcode == frwl_pkg::OP_WRITE_REL);
    r.agent_id = op.requester_id;
    r.is_write = wr;
    r.last     = 1'b0;
    case (op.opcode)
      frwl_pkg::OP_READ_REQ, frwl_pkg::OP_WRITE_REQ: begin
        if (fifo_count >= frwl_pkg::QUEUE_DEPTH) begin
          r.result_kind = frwl_pkg::RK_REJECTED;
        end else if (fifo_count > 0 || writer_held ||
                     (wr ? readers_held > 0
                         : readers_held >= frwl_pkg::READERS_MAX)) begin
          wait_fifo[fifo_tail] = {wr, op.requester_id};
          fifo_tail = (fifo_tail + 1) % frwl_pkg::QUEUE_DEPTH;
          fifo_count++;
          r.result_kind = frwl_pkg::RK_QUEUED;
        end else begin
          if (wr) begin
            writer_held = 1'b1;
          end else begin
            readers_held++;
          end
          r.result_kind = frwl_pkg::RK_GRANTED;
        end
      end
      frwl_pkg::OP_READ_REL: begin
        if (readers_held == 0) begin
          r.result_kind = frwl_pkg::RK_REL_ERROR;
        end else begin
          readers_held--;
          r.result_kind = frwl_pkg::RK_RELEASED;
        end
      end
      default: begin
        if (!writer_held) begin
          r.result_kind = frwl_pkg::RK_REL_ERROR;
        end else begin
          writer_held = 1'b0;
          r.result_kind = frwl_pkg::RK_RELEASED;
        end
      end
    endcase
    res.push_back(r);

    // serve the head of the wait queue while the lock allows it
    if (fifo_count > 0 && !writer_held) begin
      head_entry = wait_fifo[fifo_head];
      if (head_entry[frwl_pkg::ID_BITS]) begin
        if (readers_held == 0 && res.size() < frwl_pkg::MAX_RESULTS) begin
          fifo_head = (fifo_head + 1) % frwl_pkg::QUEUE_DEPTH;
          fifo_count--;
          writer_held   = 1'b1;
          r.result_kind = frwl_pkg::RK_WAITER_GRANT;
          r.agent_id    = head_entry[frwl_pkg::ID_BITS-1:0];
          r.is_write    = 1'b1;
          res.push_back(r);
        end
      end else begin
        while (fifo_count > 0 && !wait_fifo[fifo_head][frwl_pkg::ID_BITS] &&
               res.size() < frwl_pkg::MAX_RESULTS &&
               readers_held < frwl_pkg::READERS_MAX) begin
          head_entry = wait_fifo[fifo_head];
          fifo_head = (fifo_head + 1) % frwl_pkg::QUEUE_DEPTH;
          fifo_count--;
          readers_held++;
          r.result_kind = frwl_pkg::RK_WAITER_GRANT;
          r.agent_id    = head_entry[frwl_pkg::ID_BITS-1:0];
          r.is_write    = 1'b0;
          res.push_back(r);
        end
      end
    end
    res[res.size()-1].last = 1'b1;
    foreach (res[i]) awaited_results.push_back(res[i]);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_lock_op(input frwl_pkg::in_item_t op);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (!in_ready);
    arbitrate_lock_op(op);
    @(negedge clk);
  endtask

  task automatic send_op(input frwl_pkg::opcode_t opc,
                         input logic [frwl_pkg::ID_BITS-1:0] id);
    frwl_pkg::in_item_t op;
    op.opcode       = opc;
    op.requester_id = id;
    send_lock_op(op);
  endtask

  // mostly well-formed traffic: releases follow the holders the lock has
  function automatic frwl_pkg::in_item_t pick_lock_op();
    frwl_pkg::in_item_t op;
    int                 r;
    r = $urandom_range(99);
    op.requester_id = frwl_pkg::ID_BITS'($urandom_range(255));
    if (r < 10) begin
      op.opcode = frwl_pkg::opcode_t'($urandom_range(3));
    end else if (writer_held && r < 35) begin
      op.opcode = frwl_pkg::OP_WRITE_REL;
    end else if (readers_held > 0 && r < 55) begin
      op.opcode = frwl_pkg::OP_READ_REL;
    end else if (r < 80) begin
      op.opcode = frwl_pkg::OP_READ_REQ;
    end else begin
      op.opcode = frwl_pkg::OP_WRITE_REQ;
    end
    return op;
  endfunction

  // releases holders until the lock is free and nobody waits
  task automatic settle_lock();
    while (writer_held || readers_held > 0 || fifo_count > 0) begin
      if (writer_held) begin
        send_op(frwl_pkg::OP_WRITE_REL, frwl_pkg::ID_BITS'($urandom_range(255)));
      end else begin
        send_op(frwl_pkg::OP_READ_REL, frwl_pkg::ID_BITS'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_basic_ops();
    send_idle_pct = 29;
    recv_idle_pct = 50;
    settle_lock();
    send_op(frwl_pkg::OP_READ_REQ, 8'h00);
    send_op(frwl_pkg::OP_READ_REQ, 8'hff);
    send_op(frwl_pkg::OP_WRITE_REQ, 8'h80);   // waits behind two readers
    send_op(frwl_pkg::OP_READ_REQ, 8'h01);    // waits behind the writer
    send_op(frwl_pkg::OP_READ_REL, 8'h00);
    send_op(frwl_pkg::OP_READ_REL, 8'hff);    // last reader out hands over to the writer
    send_op(frwl_pkg::OP_WRITE_REL, 8'h80);
    send_op(frwl_pkg::OP_READ_REL, 8'h01);
    send_op(frwl_pkg::OP_READ_REL, 8'h55);    // no reader holds the lock
    send_op(frwl_pkg::OP_WRITE_REL, 8'haa);   // no writer holds the lock
    send_op(frwl_pkg::OP_WRITE_REQ, 8'hff);
    send_op(frwl_pkg::OP_WRITE_REQ, 8'h00);
    send_op(frwl_pkg::OP_WRITE_REL, 8'hff);
    send_op(frwl_pkg::OP_WRITE_REL, 8'h00);
  endtask

  task automatic test_queue_full();
    send_idle_pct = 29;
    recv_idle_pct = 50;
    settle_lock();
    send_op(frwl_pkg::OP_WRITE_REQ, 8'h11);
    for (int i = 0; i < frwl_pkg::QUEUE_DEPTH; i++) begin
      send_op(frwl_pkg::OP_READ_REQ, 8'(i * 17));
    end
    send_op(frwl_pkg::OP_READ_REQ, 8'hee);
    send_op(frwl_pkg::OP_WRITE_REQ, 8'h77);
    // release wakes more readers than fit in one burst, the rest wait
    send_op(frwl_pkg::OP_WRITE_REL, 8'h11);
    send_op(frwl_pkg::OP_READ_REL, 8'h00);
    settle_lock();
  endtask

  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 150;
    repeat (24) send_lock_op(pick_lock_op());
  endtask

  task automatic test_random_traffic(input int count, input int send_pct,
                                     input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_lock_op(pick_lock_op());
  endtask

  initial begin : receiver
    int hold;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    frwl_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected item: result_kind %0d agent_id %0d", out_data.result_kind,
               out_data.agent_id);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_data.result_kind !== want.result_kind) begin
          $error("result_kind: expected %0d, actual %0d", want.result_kind,
                 out_data.result_kind);
          fail_count++;
        end
        if (out_data.agent_id !== want.agent_id) begin
          $error("agent_id: expected %0d, actual %0d", want.agent_id, out_data.agent_id);
          fail_count++;
        end
        if (out_data.is_write !== want.is_write) begin
          $error("is_write: expected %0d, actual %0d", want.is_write, out_data.is_write);
          fail_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_data.last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    fail_count    = 0;
    cycle_count   = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 0;
    fifo_head     = 0;
    fifo_tail     = 0;
    fifo_count    = 0;
    readers_held  = 0;
    writer_held   = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_basic_ops();
    test_queue_full();
    test_output_stall();
    test_random_traffic(120, 29, 50);
    test_random_traffic(120, 50, 29);
    test_random_traffic(110, 0, 0);
    in_valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("fair_reader_writer_lock_arbiter regression: pass");
    end else begin
      $display("fair_reader_writer_lock_arbiter regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/frwl_pkg.sv
hw/rtl/frwl_ram.sv
hw/rtl/frwl_ctrl.sv
hw/rtl/frwl_datapath.sv
hw/rtl/fair_reader_writer_lock_arbiter.sv
bench/tb_fair_reader_writer_lock_arbiter.sv
